>>> rtl/weighted_priority_queue_with_aging_assert.svh
// Assertion macros for the weighted priority queue with aging.
// Included by the top level; depends on nothing else.
`ifndef WEIGHTED_PRIORITY_QUEUE_WITH_AGING_ASSERT_SVH
`define WEIGHTED_PRIORITY_QUEUE_WITH_AGING_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define WPQA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the cycle after the antecedent.
`define WPQA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/wpqa_pkg.sv
// Package for the weighted priority queue with aging.
// Holds widths, command and status codes and register defaults; no dependencies.
package wpqa_pkg;
    localparam int unsigned DEF_QUEUE_DEPTH = 128;
    localparam int unsigned ID_W   = 16;
    localparam int unsigned CAT_W  = 3;
    localparam int unsigned ESC_W  = 16;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned REG_W  = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned OCC_W  = 8;
    localparam int unsigned WGT_W  = 17;

    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_DEQUEUE = 2'd1,
        CMD_TICK    = 2'd2,
        CMD_AGE     = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    localparam logic [CFG_IDX_W-1:0] REG_STALE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESTOCK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STD     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RUSH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VIP     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RECALL  = 3'd6;

    localparam logic [CAT_W-1:0] CAT_STD    = 3'd1;
    localparam logic [CAT_W-1:0] CAT_RUSH   = 3'd2;
    localparam logic [CAT_W-1:0] CAT_VIP    = 3'd3;
    localparam logic [CAT_W-1:0] CAT_RECALL = 3'd4;

    localparam logic [REG_W-1:0] RST_STALE   = 16'd4;
    localparam logic [REG_W-1:0] RST_STEP    = 16'd50;
    localparam logic [REG_W-1:0] RST_RESTOCK = 16'd200;
    localparam logic [REG_W-1:0] RST_STD     = 16'd400;
    localparam logic [REG_W-1:0] RST_RUSH    = 16'd600;
    localparam logic [REG_W-1:0] RST_VIP     = 16'd800;
    localparam logic [REG_W-1:0] RST_RECALL  = 16'd10000;

    localparam int unsigned ENTRY_W = ID_W + CAT_W + TIME_W + ESC_W;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [CAT_W-1:0]  cat;
        logic [TIME_W-1:0] logged;
        logic [ESC_W-1:0]  esc;
    } t_entry;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [ID_W-1:0]  ticket_id;
        logic [CAT_W-1:0] category;
        logic [ESC_W-1:0] initial_escalation;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic [ID_W-1:0]  out_ticket_id;
        logic [CAT_W-1:0] out_category;
        logic [ESC_W-1:0] out_escalation;
        logic             recall_present;
        logic [OCC_W-1:0] occupancy;
    } t_rsp;
endpackage

>>> rtl/wpqa_req_if.sv
// Request channel interface (valid/ready).
// Depends on wpqa_pkg.
interface wpqa_req_if import wpqa_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/wpqa_rsp_if.sv
// Response channel interface (valid/ready).
// Depends on wpqa_pkg.
interface wpqa_rsp_if import wpqa_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/wpqa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module wpqa_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> rtl/weighted_priority_queue_with_aging.sv
// Weighted priority queue with aging: top level, sequencer and entry store.
// Depends on wpqa_pkg, wpqa_req_if, wpqa_rsp_if, wpqa_ram and the assert header.
// Insert and tick answer straight from the idle state; a dequeue walks the store to find
// the winner, then shifts the entries above it down, and an aging scan walks the store once
// (one shared RAM read port walks the store).
// Throughput: one request at a time; ready is low while a request is in progress.
// Reset (synchronous, active low) empties the backlog, zeroes time and loads
// register defaults; entry RAM is not cleared (entries past the count are never used).
`include "weighted_priority_queue_with_aging_assert.svh"
module weighted_priority_queue_with_aging
    import wpqa_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [REG_W-1:0]     i_cfg_data,
    wpqa_req_if.sink             req,
    wpqa_rsp_if.source           rsp
);
    localparam int unsigned AW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_FIND, S_SHIFT, S_AGE, S_DONE
    } t_state;

    // configuration registers
    logic [REG_W-1:0] r_stale, r_step, r_w0, r_w1, r_w2, r_w3, r_w4;

    t_state            r_state;
    logic [CW-1:0]     r_count;
    logic [TIME_W-1:0] r_time;
    logic [CW-1:0]     r_idx;      // read address issued this cycle (walk pointer)
    logic              r_rd_vld;   // RAM output holds entry r_idx-1
    logic [AW-1:0]     r_best;
    logic [WGT_W-1:0]  r_best_w;
    logic              r_have_best;
    logic              r_recall;
    t_rsp              r_rsp;
    logic              r_rsp_vld;
    t_rsp              n_rsp;

    // RAM port
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    t_entry        ram_wdata, ram_rdata;

    wpqa_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    logic             accept;
    logic [CW-1:0]    prev_idx;
    logic [REG_W-1:0] base_w;
    logic [WGT_W-1:0] cur_w;
    logic [TIME_W-1:0] wait_t;
    logic [ESC_W:0]   aged_sum;
    logic [ESC_W-1:0] aged_esc;

    assign accept    = req.valid && req.ready;
    assign req.ready = (r_state == S_IDLE) && !r_rsp_vld;
    assign rsp.valid = r_rsp_vld;
    assign rsp.data  = r_rsp;
    assign prev_idx  = r_idx - CW'(1);

    // shared weight / aging unit on the RAM read data
    always_comb begin
        case (ram_rdata.cat)
            CAT_RECALL: base_w = r_w4;
            CAT_VIP:    base_w = r_w3;
            CAT_RUSH:   base_w = r_w2;
            CAT_STD:    base_w = r_w1;
            default:    base_w = r_w0;
        endcase
        cur_w    = {1'b0, base_w} + {1'b0, ram_rdata.esc};
        wait_t   = r_time - ram_rdata.logged;
        aged_sum = {1'b0, ram_rdata.esc} + {1'b0, r_step};
        aged_esc = aged_sum[ESC_W] ? {ESC_W{1'b1}} : aged_sum[ESC_W-1:0];
    end

    // response loaded at acceptance; a walk fills in the rest later
    always_comb begin
        n_rsp = '0;
        n_rsp.occupancy = OCC_W'(r_count);
        case (t_cmd'(req.data.cmd))
            CMD_INSERT: begin
                if (r_count < CW'(QUEUE_DEPTH)) begin
                    n_rsp.occupancy = OCC_W'(r_count + CW'(1));
                end else begin
                    n_rsp.status = ST_FULL;
                end
            end
            CMD_DEQUEUE: begin
                if (r_count == '0) begin
                    n_rsp.status = ST_EMPTY;
                end
            end
            default: ;
        endcase
    end

    // RAM port steering
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_count[AW-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = r_idx[AW-1:0];
        case (r_state)
            S_IDLE: begin
                // prefetch entry 0 so a walk starts with valid read data
                ram_raddr = '0;
                ram_we    = accept && (t_cmd'(req.data.cmd) == CMD_INSERT)
                            && (r_count < CW'(QUEUE_DEPTH));
                ram_waddr = r_count[AW-1:0];
                ram_wdata.id     = req.data.ticket_id;
                ram_wdata.cat    = req.data.category;
                ram_wdata.logged = r_time;
                ram_wdata.esc    = req.data.initial_escalation;
            end
            S_SHIFT: begin
                // first cycle: fetch the entry just above best
                if (r_idx == '0) begin
                    ram_raddr = AW'(CW'(r_best) + CW'(1));
                end
                // move entry r_idx-1 down one slot
                ram_we    = r_rd_vld;
                ram_waddr = AW'(prev_idx - CW'(1));
            end
            S_AGE: begin
                ram_we    = r_rd_vld && (ram_rdata.cat != CAT_RECALL)
                            && (wait_t > TIME_W'(r_stale));
                ram_waddr = prev_idx[AW-1:0];
                ram_wdata.esc = aged_esc;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stale <= RST_STALE;  r_step <= RST_STEP;
            r_w0 <= RST_RESTOCK;   r_w1 <= RST_STD;   r_w2 <= RST_RUSH;
            r_w3 <= RST_VIP;       r_w4 <= RST_RECALL;
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_time      <= '0;
            r_idx       <= '0;
            r_rd_vld    <= 1'b0;
            r_have_best <= 1'b0;
            r_recall    <= 1'b0;
            r_rsp_vld   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_STALE:   r_stale <= i_cfg_data;
                    REG_STEP:    r_step  <= i_cfg_data;
                    REG_RESTOCK: r_w0    <= i_cfg_data;
                    REG_STD:     r_w1    <= i_cfg_data;
                    REG_RUSH:    r_w2    <= i_cfg_data;
                    REG_VIP:     r_w3    <= i_cfg_data;
                    REG_RECALL:  r_w4    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (rsp.valid && rsp.ready) begin
                r_rsp_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_rsp       <= n_rsp;
                        r_idx       <= '0;
                        r_rd_vld    <= 1'b0;
                        r_have_best <= 1'b0;
                        r_recall    <= 1'b0;
                        case (t_cmd'(req.data.cmd))
                            CMD_INSERT: begin
                                if (r_count < CW'(QUEUE_DEPTH)) begin
                                    r_count <= r_count + CW'(1);
                                end
                                r_rsp_vld <= 1'b1;
                            end
                            CMD_TICK: begin
                                r_time <= r_time + TIME_W'(1);
                                r_rsp_vld <= 1'b1;
                            end
                            CMD_DEQUEUE: begin
                                if (r_count == '0) begin
                                    r_rsp_vld    <= 1'b1;
                                end else begin
                                    r_state <= S_FIND;
                                    r_idx   <= CW'(1);
                                    r_rd_vld <= 1'b1;
                                end
                            end
                            default: begin
                                r_state  <= S_AGE;
                                r_idx    <= CW'(1);
                                r_rd_vld <= (r_count != '0);
                            end
                        endcase
                    end
                end
                S_FIND: begin
                    // compare entry r_idx-1; strict greater keeps earliest on ties
                    if (r_rd_vld && (!r_have_best || cur_w > r_best_w)) begin
                        r_have_best <= 1'b1;
                        r_best_w    <= cur_w;
                        r_best      <= prev_idx[AW-1:0];
                        r_rsp.out_ticket_id  <= ram_rdata.id;
                        r_rsp.out_category   <= ram_rdata.cat;
                        r_rsp.out_escalation <= ram_rdata.esc;
                    end
                    if (r_idx < r_count) begin
                        r_idx <= r_idx + CW'(1);
                    end else begin
                        r_state  <= S_SHIFT;
                        r_rd_vld <= 1'b0;
                        r_idx    <= '0;
                    end
                end
                S_SHIFT: begin
                    // read the entries from best+1 onward, write each one slot lower
                    if (r_idx == '0) begin
                        r_idx    <= CW'(r_best) + CW'(2);
                        r_rd_vld <= (CW'(r_best) + CW'(1) < r_count);
                        if (!(CW'(r_best) + CW'(1) < r_count)) begin
                            r_state <= S_DONE;
                        end
                    end else if (r_idx < r_count) begin
                        r_idx <= r_idx + CW'(1);
                    end else begin
                        r_rd_vld <= 1'b0;
                        r_state  <= S_DONE;
                    end
                end
                S_AGE: begin
                    if (r_rd_vld && ram_rdata.cat == CAT_RECALL) begin
                        r_recall <= 1'b1;
                    end
                    if (r_rd_vld && r_idx < r_count) begin
                        r_idx <= r_idx + CW'(1);
                    end else begin
                        r_rd_vld <= 1'b0;
                        r_state  <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (r_have_best) begin
                        r_count <= r_count - CW'(1);
                        r_rsp.occupancy <= OCC_W'(r_count - CW'(1));
                    end else begin
                        r_rsp.recall_present <= r_recall;
                    end
                    r_rsp_vld <= 1'b1;
                    r_state   <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // occupancy never exceeds the store depth
    `WPQA_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= CW'(QUEUE_DEPTH), "entry count exceeds depth")
    // no request is taken while a response is pending
    `WPQA_ASSERT_IMPL(a_no_overlap, i_clk, i_rst_n, r_rsp_vld && !rsp.ready,
        !req.ready, "request accepted over pending response")
    // a dequeue that finds an entry always decrements the count
    `WPQA_ASSERT_NEXT(a_deq_dec, i_clk, i_rst_n, r_state == S_DONE && r_have_best,
        r_count == $past(r_count) - CW'(1), "dequeue did not remove an entry")
endmodule

>>> tb/wpqa_tb_pkg.sv
// Shared constants for the backlog testbench: idle phases, idle percentages and watchdog limit.
// Depends on wpqa_pkg.
package wpqa_tb_pkg;
    import wpqa_pkg::*;

    typedef enum int {
        PH_STEADY,
        PH_SENDER_IDLE,
        PH_RECEIVER_STALL,
        PH_BOTH_IDLE
    } t_phase;

    localparam int unsigned IDLE_PERCENT = 77;
    localparam int unsigned BOTH_PERCENT = 11;
    localparam int unsigned WATCHDOG_LIMIT = 20000;
endpackage

>>> tb/testbench.sv
// Self-checking testbench for the weighted priority backlog with aging.
// Depends on wpqa_pkg, wpqa_tb_pkg, wpqa_req_if, wpqa_rsp_if and the block.
// A directed table runs first, then a fill past full and an emptying, then random phases under four idle patterns.
module testbench
    import wpqa_pkg::*, wpqa_tb_pkg::*;
;
    localparam int unsigned DEPTH = DEF_QUEUE_DEPTH;
    localparam int unsigned DRAIN_CYCLES = 2 * DEPTH + 20;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = REG_STALE;
    logic [REG_W-1:0]     cfg_data = '0;

    wpqa_req_if req_ch ();
    wpqa_rsp_if rsp_ch ();

    weighted_priority_queue_with_aging #(.QUEUE_DEPTH(DEPTH)) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .req        (req_ch.sink),
        .rsp        (rsp_ch.source)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: own copy of registers and backlog.
    logic [REG_W-1:0]  regs [0:6];
    logic [ID_W-1:0]   bl_id   [$];
    logic [CAT_W-1:0]  bl_cat  [$];
    logic [TIME_W-1:0] bl_time [$];
    logic [ESC_W-1:0]  bl_esc  [$];
    logic [TIME_W-1:0] tick_count;

    t_rsp   pending_rsp [$];
    int     error_count = 0;
    int     idle_cycles = 0;
    t_phase phase = PH_STEADY;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    function automatic logic [WGT_W-1:0] order_weight(input int k);
        logic [REG_W-1:0] base;
        case (bl_cat[k])
            CAT_RECALL: base = regs[REG_RECALL];
            CAT_VIP:    base = regs[REG_VIP];
            CAT_RUSH:   base = regs[REG_RUSH];
            CAT_STD:    base = regs[REG_STD];
            default:    base = regs[REG_RESTOCK];
        endcase
        return {1'b0, base} + {1'b0, bl_esc[k]};
    endfunction

    // Apply one request to the predictor and return the result it causes.
    function automatic t_rsp backlog_step(input t_req r);
        t_rsp              o;
        int                best;
        logic [WGT_W-1:0]  best_w;
        logic [TIME_W-1:0] wait_t;
        logic [ESC_W:0]    sum;
        o = '0;
        case (t_cmd'(r.cmd))
            CMD_INSERT: begin
                if (bl_id.size() >= DEPTH) begin
                    o.status = ST_FULL;
                end else begin
                    bl_id.push_back(r.ticket_id);
                    bl_cat.push_back(r.category);
                    bl_time.push_back(tick_count);
                    bl_esc.push_back(r.initial_escalation);
                end
            end
            CMD_DEQUEUE: begin
                if (bl_id.size() == 0) begin
                    o.status = ST_EMPTY;
                end else begin
                    best = 0;
                    best_w = order_weight(0);
                    for (int k = 1; k < bl_id.size(); k++) begin
                        if (order_weight(k) > best_w) begin
                            best_w = order_weight(k);
                            best = k;
                        end
                    end
                    o.out_ticket_id  = bl_id[best];
                    o.out_category   = bl_cat[best];
                    o.out_escalation = bl_esc[best];
                    bl_id.delete(best);
                    bl_cat.delete(best);
                    bl_time.delete(best);
                    bl_esc.delete(best);
                end
            end
            CMD_TICK: tick_count = tick_count + TIME_W'(1);
            default: begin
                for (int k = 0; k < bl_id.size(); k++) begin
                    wait_t = tick_count - bl_time[k];
                    if (bl_cat[k] == CAT_RECALL) begin
                        o.recall_present = 1'b1;
                    end else if (wait_t > {16'd0, regs[REG_STALE]}) begin
                        sum = {1'b0, bl_esc[k]} + {1'b0, regs[REG_STEP]};
                        bl_esc[k] = sum[ESC_W] ? '1 : sum[ESC_W-1:0];
                    end
                end
            end
        endcase
        o.occupancy = OCC_W'(bl_id.size());
        return o;
    endfunction

    function automatic t_req make_req(input t_cmd c, input int id, input int cat, input int esc);
        t_req r;
        r.cmd = c;
        r.ticket_id = ID_W'(id);
        r.category = CAT_W'(cat);
        r.initial_escalation = ESC_W'(esc);
        return r;
    endfunction

    // Receiver: stall per phase, compare each result with the oldest one waiting.
    always @(posedge i_clk) begin
        if (rsp_ch.valid && rsp_ch.ready && i_rst_n) begin
            if (pending_rsp.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                t_rsp w;
                w = pending_rsp.pop_front();
                if (rsp_ch.data.status != w.status)
                    report_mismatch("status", int'(rsp_ch.data.status), int'(w.status));
                if (rsp_ch.data.out_ticket_id != w.out_ticket_id)
                    report_mismatch("ticket id", int'(rsp_ch.data.out_ticket_id),
                                    int'(w.out_ticket_id));
                if (rsp_ch.data.out_category != w.out_category)
                    report_mismatch("category", int'(rsp_ch.data.out_category),
                                    int'(w.out_category));
                if (rsp_ch.data.out_escalation != w.out_escalation)
                    report_mismatch("escalation", int'(rsp_ch.data.out_escalation),
                                    int'(w.out_escalation));
                if (rsp_ch.data.recall_present != w.recall_present)
                    report_mismatch("recall", int'(rsp_ch.data.recall_present),
                                    int'(w.recall_present));
                if (rsp_ch.data.occupancy != w.occupancy)
                    report_mismatch("occupancy", int'(rsp_ch.data.occupancy),
                                    int'(w.occupancy));
            end
        end
        case (phase)
            PH_RECEIVER_STALL: rsp_ch.ready <= ($urandom_range(99) >= IDLE_PERCENT);
            PH_BOTH_IDLE:      rsp_ch.ready <= ($urandom_range(99) >= BOTH_PERCENT);
            default:           rsp_ch.ready <= 1'b1;
        endcase
    end

    // Watchdog: count cycles in which nothing is accepted.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // Write one register at an edge and mirror it in the predictor.
    // The caller drops the write enable after its last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        regs[idx] = val;
    endtask

    // Send one request: hold valid until accepted, predict at acceptance.
    // Valid stays high between back-to-back requests; drop it only for a gap.
    task automatic send_req(input t_req r);
        int gap_pct;
        gap_pct = (phase == PH_SENDER_IDLE) ? IDLE_PERCENT :
                  (phase == PH_BOTH_IDLE) ? BOTH_PERCENT : 0;
        if ($urandom_range(99) < gap_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < gap_pct) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        pending_rsp.push_back(backlog_step(r));
    endtask

    // Wait for every expected result, then let the block settle.
    task automatic drain;
        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Random request: mostly inserts and dequeues, fewer ticks and scans.
    function automatic t_req random_req(input int fill_bias);
        int   pick;
        t_cmd c;
        int   esc;
        pick = $urandom_range(99);
        if (pick < fill_bias) c = CMD_INSERT;
        else if (pick < 75) c = CMD_DEQUEUE;
        else if (pick < 90) c = CMD_TICK;
        else c = CMD_AGE;
        esc = ($urandom_range(9) == 0) ? $urandom_range(65535, 65000) :
              ($urandom_range(3) == 0) ? $urandom : $urandom_range(300);
        return make_req(c, $urandom, $urandom_range(7), esc);
    endfunction

    typedef struct {
        t_req req;
        bit   known;
        t_rsp want;
    } t_row;

    initial begin
        t_row  rows [$];
        t_row  row;
        t_rsp  want;
        t_phase phases [4];
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        phases = '{PH_STEADY, PH_SENDER_IDLE, PH_RECEIVER_STALL, PH_BOTH_IDLE};

        regs[REG_STALE] = RST_STALE;     regs[REG_STEP] = RST_STEP;
        regs[REG_RESTOCK] = RST_RESTOCK; regs[REG_STD] = RST_STD;
        regs[REG_RUSH] = RST_RUSH;       regs[REG_VIP] = RST_VIP;
        regs[REG_RECALL] = RST_RECALL;
        tick_count = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: known rows are checked against typed-in results.
        want = '0; want.status = ST_EMPTY;
        rows.push_back('{make_req(CMD_DEQUEUE, 0, 0, 0), 1, want});
        want = '0;
        rows.push_back('{make_req(CMD_AGE, 0, 0, 0), 1, want});
        want = '0; want.occupancy = 1;
        rows.push_back('{make_req(CMD_INSERT, 16'hFFFF, 7, 16'hFFFF), 1, want});
        want = '0; want.out_ticket_id = 16'hFFFF; want.out_category = 7;
        want.out_escalation = 16'hFFFF;
        rows.push_back('{make_req(CMD_DEQUEUE, 0, 0, 0), 1, want});
        // Tie between equal weights: earliest wins.
        rows.push_back('{make_req(CMD_INSERT, 1, 1, 0), 0, want});
        rows.push_back('{make_req(CMD_INSERT, 2, 0, 200), 0, want});
        rows.push_back('{make_req(CMD_INSERT, 3, CAT_RECALL, 0), 0, want});
        rows.push_back('{make_req(CMD_INSERT, 4, 5, 65500), 0, want});
        for (int k = 0; k < 6; k++)
            rows.push_back('{make_req(CMD_TICK, 0, 0, 0), 0, want});
        rows.push_back('{make_req(CMD_AGE, 0, 0, 0), 0, want});
        rows.push_back('{make_req(CMD_AGE, 0, 0, 0), 0, want});
        for (int k = 0; k < 5; k++)
            rows.push_back('{make_req(CMD_DEQUEUE, 0, 0, 0), 0, want});
        foreach (rows[k]) begin
            send_req(rows[k].req);
            if (rows[k].known) pending_rsp[pending_rsp.size()-1] = rows[k].want;
        end
        drain();

        // Fill past full, then empty again.
        for (int k = 0; k < DEPTH + 3; k++) send_req(make_req(CMD_INSERT, k, k % 5, 0));
        drain();
        write_reg(REG_RECALL, 16'd0);
        cfg_we <= 1'b0;
        for (int k = 0; k < DEPTH + 2; k++) send_req(make_req(CMD_DEQUEUE, 0, 0, 0));
        drain();

        // Random phases, each under its own register setting.
        for (int p = 0; p < 8; p++) begin
            phase = phases[p % 4];
            if (p == 1) begin
                for (int k = 0; k < 7; k++) write_reg(CFG_IDX_W'(k), 16'hFFFF);
            end else if (p == 2) begin
                for (int k = 0; k < 7; k++) write_reg(CFG_IDX_W'(k), 16'd0);
            end else begin
                for (int k = 0; k < 7; k++)
                    write_reg(CFG_IDX_W'(k), (k == REG_STALE) ? REG_W'($urandom_range(8))
                                                              : REG_W'($urandom_range(1000)));
            end
            cfg_we <= 1'b0;
            for (int n = 0; n < 146; n++) send_req(random_req((n % 90 < 45) ? 55 : 30));
            drain();
        end

        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end
endmodule

>>> files.f
+incdir+rtl
rtl/wpqa_pkg.sv
rtl/wpqa_req_if.sv
rtl/wpqa_rsp_if.sv
rtl/wpqa_ram.sv
rtl/weighted_priority_queue_with_aging.sv
tb/wpqa_tb_pkg.sv
tb/testbench.sv
